@@ rtl/core/hcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the prefix-code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int NUM_SYMBOLS_DEF  = 256;

  localparam int BYTE_W  = 8;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 5;
  localparam int CMD_W   = 2;
  localparam int ACC_W   = 3;
  localparam int VAL_W   = CODE_W + BYTE_W - 1;
  localparam int TOT_W   = $clog2(VAL_W + 1);

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  typedef struct packed {
    logic enc;
    logic flush;
  } op_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_rd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/huffman_code_bit_packer_top.sv @@
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Prefix-code bit packer with a loadable per-symbol code table.
//
// Input channel (in_*): one command item per handshake. Load writes a table
// entry, encode appends the symbol's code to the bit accumulator, flush
// emits the pending partial byte padded with zeros in its low bits.
// Result channel (out_*): packed bytes, earliest bit in bit 7, with out_last
// on the final byte that an item produces.
// Timing: the table is read when an item is accepted, and the pack stage
// writes its bytes into the result queue once the queue has room; the
// first byte can then be taken from the queue.
// Throughput: one item per cycle while the result queue has room; the
// result side drains one byte per cycle, so two-byte items are paced by
// the drain. The single table read port sets the one-item pace.
// Reset: table entries read as unused, accumulator and queue empty.
// Receiver stall: the four-entry queue fills, the pack stage holds its
// item, and in_ready drops until space returns.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [hcbp_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [hcbp_pkg::SYM_W-1:0]  in_symbol,
  input  wire logic [hcbp_pkg::CODE_W-1:0] in_code_bits,
  input  wire logic [hcbp_pkg::LEN_W-1:0]  in_code_len,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [hcbp_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_last
);

  localparam int IDX_W = $clog2(NUM_SYMBOLS);

  logic              accept, sym_ok, wr_en, s1_fire, room;
  logic              s1_vld_r;
  hcbp_pkg::op_t     s1_op_r, op_nxt;
  hcbp_pkg::tbl_rd_t rd;
  hcbp_pkg::res_t    res0, res1, q;
  logic [1:0]        push_n, push_g;
  logic [IDX_W-1:0]  idx;

  assign sym_ok   = ({1'b0, in_symbol} < 9'(NUM_SYMBOLS));
  assign idx      = in_symbol[IDX_W-1:0];
  assign s1_fire  = s1_vld_r & room;
  assign in_ready = ~s1_vld_r | s1_fire;
  assign accept   = in_valid & in_ready;
  assign wr_en    = accept & (in_cmd == hcbp_pkg::CMD_LOAD) & sym_ok;
  assign op_nxt.enc   = (in_cmd == hcbp_pkg::CMD_ENCODE) & sym_ok;
  assign op_nxt.flush = (in_cmd == hcbp_pkg::CMD_FLUSH);
  assign push_g   = s1_fire ? push_n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_op_r  <= '0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
      s1_op_r  <= op_nxt;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  hcbp_code_table #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_idx  (idx),
    .wr_code (in_code_bits),
    .wr_len  (in_code_len),
    .rd_en   (accept),
    .rd_idx  (idx),
    .rd_data (rd)
  );

  hcbp_packer u_packer (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .op     (s1_op_r),
    .rd     (rd),
    .push_n (push_n),
    .res0   (res0),
    .res1   (res1)
  );

  hcbp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_g),
    .d0        (res0),
    .d1        (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .q         (q)
  );

  assign out_byte = q.data;
  assign out_last = q.last;

endmodule

`default_nettype wire

@@ rtl/core/hcbp_code_table.sv @@
// ----------------------------------------------------------------------------
// hcbp_code_table
// Code table memory with per-entry valid bits and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_code_table #(
  parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  localparam int IDX_W = $clog2(NUM_SYMBOLS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [IDX_W-1:0]           wr_idx,
  input  wire logic [hcbp_pkg::CODE_W-1:0] wr_code,
  input  wire logic [hcbp_pkg::LEN_W-1:0] wr_len,
  input  wire logic                       rd_en,
  input  wire logic [IDX_W-1:0]           rd_idx,
  output hcbp_pkg::tbl_rd_t               rd_data
);

  localparam int CW = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W;
  localparam int LW = $clog2(CW + 1);

  logic [CW+LW-1:0]       mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld_r;
  logic [CW-1:0]          rd_code_r;
  logic [LW-1:0]          rd_len_r;
  logic                   rd_hit_r;
  logic [LW-1:0]          len_sat;
  logic [CW-1:0]          code_m;

  always_comb begin
    if (wr_len > hcbp_pkg::LEN_W'(CW)) begin
      len_sat = LW'(CW);
    end else begin
      len_sat = LW'(wr_len);
    end
    for (int i = 0; i < CW; i++) begin
      code_m[i] = wr_code[i] & (i < int'(len_sat));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {code_m, len_sat};
    end
    if (rd_en) begin
      {rd_code_r, rd_len_r} <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data.code = hcbp_pkg::CODE_W'(rd_code_r);
  assign rd_data.len  = rd_hit_r ? hcbp_pkg::LEN_W'(rd_len_r) : '0;

endmodule

`default_nettype wire

@@ rtl/core/hcbp_packer.sv @@
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator: appends code bits and splits off completed bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_packer (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fire,
  input  hcbp_pkg::op_t                  op,
  input  hcbp_pkg::tbl_rd_t              rd,
  output logic [1:0]                     push_n,
  output hcbp_pkg::res_t                 res0,
  output hcbp_pkg::res_t                 res1
);

  logic [hcbp_pkg::BYTE_W-1:0] accum_r, accum_nxt;
  logic [hcbp_pkg::ACC_W-1:0]  count_r, count_nxt;
  logic [hcbp_pkg::VAL_W-1:0]  v;
  logic [hcbp_pkg::TOT_W-1:0]  total, t1, t2;
  logic [hcbp_pkg::ACC_W-1:0]  rem;
  logic [hcbp_pkg::BYTE_W-1:0] rem_mask;
  logic [hcbp_pkg::ACC_W:0]    pad;

  always_comb begin
    v        = (hcbp_pkg::VAL_W'(accum_r) << rd.len) | hcbp_pkg::VAL_W'(rd.code);
    total    = hcbp_pkg::TOT_W'(count_r) + hcbp_pkg::TOT_W'(rd.len);
    t1       = total - hcbp_pkg::TOT_W'(8);
    t2       = total - hcbp_pkg::TOT_W'(16);
    rem      = total[hcbp_pkg::ACC_W-1:0];
    rem_mask = (hcbp_pkg::BYTE_W'(1) << rem) - hcbp_pkg::BYTE_W'(1);
    pad      = 4'd8 - {1'b0, count_r};
    push_n    = 2'd0;
    res0.data = hcbp_pkg::BYTE_W'(v >> t1);
    res0.last = 1'b1;
    res1.data = hcbp_pkg::BYTE_W'(v >> t2);
    res1.last = 1'b1;
    accum_nxt = accum_r;
    count_nxt = count_r;
    if (op.enc && (rd.len != '0)) begin
      accum_nxt = v[hcbp_pkg::BYTE_W-1:0] & rem_mask;
      count_nxt = rem;
      if (total >= hcbp_pkg::TOT_W'(16)) begin
        push_n    = 2'd2;
        res0.last = 1'b0;
      end else if (total >= hcbp_pkg::TOT_W'(8)) begin
        push_n = 2'd1;
      end
    end else if (op.flush && (count_r != '0)) begin
      push_n    = 2'd1;
      res0.data = accum_r << pad;
      accum_nxt = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      count_r <= '0;
    end else if (fire) begin
      accum_r <= accum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hcbp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// hcbp_out_fifo
// Four-entry result queue taking up to two items per cycle, one out.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_out_fifo (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic [1:0] push_n,
  input  hcbp_pkg::res_t  d0,
  input  hcbp_pkg::res_t  d1,
  output logic          room,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hcbp_pkg::res_t  q
);

  hcbp_pkg::res_t mem [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid & out_ready;
  assign room      = (cnt_r <= 3'd2);
  assign q         = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= d0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_r + 2'd1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_r + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

`default_nettype wire
